>>> sv/gbp_pkg.sv
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared constants and word types of the gshare branch predictor.
// ----------------------------------------------------------------------------
package gbp_pkg;

  // Counter table index width; the table holds 2**INDEX_BITS counters.
  localparam int unsigned INDEX_BITS = 12;
  localparam int unsigned TABLE_DEPTH = 1 << INDEX_BITS;

  // Global history register width.
  localparam int unsigned HIST_W = 12;

  // Longest usable history: limited by the history register and the index.
  localparam int unsigned HIST_LEN_MAX = (HIST_W < INDEX_BITS) ? HIST_W : INDEX_BITS;

  localparam int unsigned CFG_W = 4;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned CTR_W = 3;

  localparam logic [CTR_W-1:0] CTR_INIT = CTR_W'(4);
  localparam logic [CTR_W-1:0] CTR_MAX  = CTR_W'(7);
  localparam logic [CTR_W-1:0] CTR_MIN  = '0;

  typedef struct packed {
    logic [31:0] branch_address;
    logic        branch_taken;
  } gbp_in_t;

  typedef struct packed {
    logic             predicted_taken;
    logic             mispredicted;
    logic [CNT_W-1:0] prediction_total;
    logic [CNT_W-1:0] misprediction_total;
  } gbp_out_t;

endpackage

>>> sv/gbp_ram.sv
// ----------------------------------------------------------------------------
// gbp_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// A read of the address being written returns the old data.
// ----------------------------------------------------------------------------
module gbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/gshare_branch_predictor.sv
// ----------------------------------------------------------------------------
// gshare_branch_predictor
// Pipeline: an accepted word has its index hashed and its counter read into
//   stage 1, then its counter updated and its result put in the output reg.
// Throughput: one branch per cycle while the output is not stalled and no
//   clear pass runs; the table read-modify-write is a two-stage pipe over
//   one RAM, with forwarding of the counter just written.
// Reset: history, totals and history_length clear at once; then a clearing
//   pass sets all 2**INDEX_BITS counters to 4, one per cycle, with the input
//   stalled. Config writes are always taken.
// ----------------------------------------------------------------------------
module gshare_branch_predictor
  import gbp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // resolved branch words
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  gbp_in_t          in_word_i,
  // prediction result words
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output gbp_out_t         out_word_o,
  // history_length register
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam logic [CFG_W-1:0] HistMax   = CFG_W'(HIST_LEN_MAX);
  localparam logic [CFG_W-1:0] HistWidth = CFG_W'(HIST_W);

  // ---------------------------------------------------------------------------
  // Control and state registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]      hist_len_q;
  logic [HIST_W-1:0]     hist_q, hist_d;

  logic                  clear_busy_q;
  logic [INDEX_BITS-1:0] clr_idx_q;

  // stage 1: table read in flight
  logic                  s1_valid_q;
  logic [INDEX_BITS-1:0] s1_idx_q;
  logic                  s1_taken_q;
  logic                  s1_fwd_q;    // RAM data is stale, use s1_fwd_ctr_q
  logic [CTR_W-1:0]      s1_fwd_ctr_q;

  // output register and running totals
  logic                  out_valid_q;
  gbp_out_t              out_word_q;
  logic [CNT_W-1:0]      pred_cnt_q, pred_cnt_d;
  logic [CNT_W-1:0]      miss_cnt_q, miss_cnt_d;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  logic s1_adv;
  logic in_accept;

  // Stage 1 moves on when the output register is empty or being drained.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clear_busy_q || (s1_valid_q && !s1_adv);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Stage 0: index hash
  // The effective history is the top h bits of the history register, with h
  // limited by the register width and the index width. It lands in the low
  // index bits.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]      hist_len_eff;
  logic [HIST_W-1:0]     hist_top;
  logic [INDEX_BITS-1:0] idx_new;

  always_comb begin
    hist_len_eff = (hist_len_q > HistMax) ? HistMax : hist_len_q;
    hist_top     = hist_q >> (HistWidth - hist_len_eff);
    idx_new      = in_word_i.branch_address[INDEX_BITS+1:2] ^ INDEX_BITS'(hist_top);
  end

  // Outcome enters at the top, older bits shift right.
  assign hist_d = {in_word_i.branch_taken, hist_q[HIST_W-1:1]};

  // ---------------------------------------------------------------------------
  // Stage 1: counter update
  // ---------------------------------------------------------------------------
  logic [CTR_W-1:0] ram_rdata;
  logic [CTR_W-1:0] ctr_cur, ctr_new;
  logic             pred, miss;

  always_comb begin
    ctr_cur = s1_fwd_q ? s1_fwd_ctr_q : ram_rdata;
    pred    = (ctr_cur >= CTR_INIT);
    miss    = (pred != s1_taken_q);
    ctr_new = ctr_cur;
    if (s1_taken_q) begin
      if (ctr_cur != CTR_MAX) ctr_new = ctr_cur + CTR_W'(1);
    end else begin
      if (ctr_cur != CTR_MIN) ctr_new = ctr_cur - CTR_W'(1);
    end
  end

  // Saturating totals; both include the branch now leaving stage 1.
  always_comb begin
    pred_cnt_d = (pred_cnt_q == '1) ? pred_cnt_q : pred_cnt_q + CNT_W'(1);
    miss_cnt_d = miss_cnt_q;
    if (miss && (miss_cnt_q != '1)) miss_cnt_d = miss_cnt_q + CNT_W'(1);
  end

  // ---------------------------------------------------------------------------
  // Counter table
  // The clearing pass owns the write port after reset. Otherwise stage 1
  // writes back its updated counter. A read issued in the same cycle as a
  // write to the same entry returns old data, so that case is flagged and
  // the new counter travels with the word instead.
  // ---------------------------------------------------------------------------
  logic                  ram_we;
  logic [INDEX_BITS-1:0] ram_waddr;
  logic [CTR_W-1:0]      ram_wdata;

  always_comb begin
    ram_we    = clear_busy_q || s1_adv;
    ram_waddr = clear_busy_q ? clr_idx_q : s1_idx_q;
    ram_wdata = clear_busy_q ? CTR_INIT : ctr_new;
  end

  gbp_ram #(
    .WIDTH (CTR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (idx_new),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_len_q   <= '0;
      hist_q       <= '0;
      clear_busy_q <= 1'b1;
      clr_idx_q    <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      pred_cnt_q   <= '0;
      miss_cnt_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        hist_len_q <= cfg_data_i;
      end

      if (clear_busy_q) begin
        clr_idx_q <= clr_idx_q + INDEX_BITS'(1);
        if (clr_idx_q == '1) clear_busy_q <= 1'b0;
      end

      if (in_accept) begin
        hist_q     <= hist_d;
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_adv) begin
        out_valid_q <= 1'b1;
        pred_cnt_q  <= pred_cnt_d;
        miss_cnt_q  <= miss_cnt_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_idx_q     <= idx_new;
      s1_taken_q   <= in_word_i.branch_taken;
      s1_fwd_q     <= s1_adv && (s1_idx_q == idx_new);
      s1_fwd_ctr_q <= ctr_new;
    end
    if (s1_adv) begin
      out_word_q.predicted_taken     <= pred;
      out_word_q.mispredicted        <= miss;
      out_word_q.prediction_total    <= pred_cnt_d;
      out_word_q.misprediction_total <= miss_cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy_q |-> !in_accept)
    else $error("word accepted during table clear");

  a_clear_ends_at_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clear_busy_q) |-> $past(clr_idx_q) == '1)
    else $error("table clear ended early");

  a_miss_le_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    miss_cnt_q <= pred_cnt_q)
    else $error("miss total above branch total");

  a_s1_empty_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy_q |-> !s1_valid_q && !out_valid_q)
    else $error("pipeline busy during table clear");

  a_total_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o && (out_word_o.prediction_total != '0))
    else $error("result total not counted");

endmodule
